// ----- rtl/core/djsel_pkg.sv -----
// shared types and constants for the deadline job selector
// no dependencies; used by the top level and its checker
`default_nettype none

package djsel_pkg;

    localparam int DUR_W          = 31;
    localparam int CNT_W          = 11;
    localparam int OUTCOME_W      = 2;
    localparam int HEAP_DEPTH_DEF = 1024;

    // stream payload widths, padded to whole bytes
    localparam int S_TDATA_W = 64;
    localparam int S_PAD_W   = S_TDATA_W - 2 * DUR_W;
    localparam int M_TDATA_W = 48;
    localparam int M_PAD_W   = M_TDATA_W - (OUTCOME_W + CNT_W + DUR_W);

    typedef enum logic [OUTCOME_W-1:0] {
        OC_ACCEPT   = 2'd0,
        OC_REPLACE  = 2'd1,
        OC_REJECT   = 2'd2,
        OC_OVERFLOW = 2'd3
    } t_outcome;

endpackage

`default_nettype wire

// ----- rtl/core/deadline_job_selector_maxheap_unit.sv -----
// deadline job selector: greedy on-time job selection over a max-heap of durations
// depends on djsel_pkg; heap kept in an internal one-write two-read memory
//
// usage:
//   slave stream takes one job per transaction: tdata holds duration (bits 30:0)
//   and deadline (61:31); tuser is the first-of-set flag that empties the heap
//   and zeroes the running total before the job is handled.
//   master stream gives one result per job: outcome (1:0), accepted count (12:2)
//   and total time (43:13).
// timing:
//   one job at a time; s_axis_tready is high only while the sequencer is idle.
//   a rejected or overflowed job passes from acceptance through the evaluate
//   step to the output register, as does an accepted job into an empty heap.
//   any other accepted job then sifts up by up to log2(HEAP_DEPTH) levels, one
//   level a cycle; a replacement sifts down by up to log2(HEAP_DEPTH) levels,
//   reading both children, then comparing, per level.
//   the heap memory and its single write port set this pace.
//   a new job is taken the cycle after its predecessor's result is registered.
// reset clears heap fill, total and output valid and holds s_axis_tready low;
// heap contents need no clearing.
// a stalled receiver holds the result in the output register; a finished job
// then waits in the sequencer, and no new job is taken, until the register frees.
`default_nettype none

module deadline_job_selector_maxheap_unit #(
    parameter int HEAP_DEPTH = djsel_pkg::HEAP_DEPTH_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // duration, deadline, zero pad
    input  wire logic [djsel_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // first_of_set
    input  wire logic                           s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // outcome, accepted_count, total_time, zero pad
    output logic [djsel_pkg::M_TDATA_W-1:0]     m_axis_tdata
);

    import djsel_pkg::*;

    localparam int FILL_W = $clog2(HEAP_DEPTH + 1);
    localparam int ADDR_W = $clog2(HEAP_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_UP,
        S_UP_FIN,
        S_DN_RD,
        S_DN_CMP,
        S_OUT
    } t_state;

    t_state              r_state;
    logic [FILL_W-1:0]   r_fill;
    logic [DUR_W-1:0]    r_total;
    logic [FILL_W-1:0]   r_pos;
    logic [DUR_W-1:0]    r_val;
    logic [DUR_W-1:0]    r_dl;
    t_outcome            r_outcome;
    logic                r_out_valid;
    t_outcome            r_out_outcome;
    logic [CNT_W-1:0]    r_out_cnt;
    logic [DUR_W-1:0]    r_out_total;

    // heap memory, position p lives at address p-1
    logic [DUR_W-1:0]    r_mem [HEAP_DEPTH];
    logic [DUR_W-1:0]    r_rd_a;
    logic [DUR_W-1:0]    r_rd_b;
    logic                w_we;
    logic [ADDR_W-1:0]   w_waddr;
    logic [DUR_W-1:0]    w_wdata;
    logic [ADDR_W-1:0]   w_raddr_a;
    logic [ADDR_W-1:0]   w_raddr_b;

    logic                w_fit;
    logic                w_full;
    logic [FILL_W-1:0]   w_new_pos;
    logic [FILL_W-1:0]   w_parent;
    logic [FILL_W-1:0]   w_pos_m1;
    logic [FILL_W-1:0]   w_npar_m1;
    logic [FILL_W-1:0]   w_gpar_m1;
    logic [FILL_W:0]     w_child2;
    logic [FILL_W:0]     w_left_m1;
    logic [FILL_W:0]     w_child;
    logic                w_pick_r;
    logic [DUR_W-1:0]    w_best;
    logic [DUR_W-1:0]    w_cmp_x;
    logic [DUR_W-1:0]    w_cmp_y;
    logic                w_ge;
    logic                w_dn_leaf;
    logic                w_out_load;
    logic [FILL_W+CNT_W-1:0] w_cnt_ext;

    assign w_fit     = ({1'b0, r_total} + {1'b0, r_val}) <= {1'b0, r_dl};
    assign w_full    = r_fill >= FILL_W'(HEAP_DEPTH);
    assign w_new_pos = r_fill + 1'b1;
    assign w_parent  = r_pos >> 1;
    assign w_pos_m1  = r_pos - 1'b1;
    assign w_npar_m1 = (w_new_pos >> 1) - 1'b1;
    assign w_gpar_m1 = (r_pos >> 2) - 1'b1;
    assign w_child2  = {r_pos, 1'b0};
    assign w_left_m1 = w_child2 - 1'b1;
    assign w_dn_leaf = r_pos > (r_fill >> 1);

    // right child exists and is strictly larger
    assign w_pick_r = (w_child2 < {1'b0, r_fill}) && (r_rd_b > r_rd_a);
    assign w_best   = w_pick_r ? r_rd_b : r_rd_a;
    assign w_child  = w_pick_r ? (w_child2 + 1'b1) : w_child2;

    // output register takes a result when empty or being read this cycle
    assign w_out_load = (r_state == S_OUT) && (!r_out_valid || m_axis_tready);

    // shared magnitude compare, operands picked by the sequencer step
    always_comb begin
        unique case (r_state)
            S_EVAL: begin
                w_cmp_x = r_val;
                w_cmp_y = r_rd_a;
            end
            S_UP: begin
                w_cmp_x = r_rd_a;
                w_cmp_y = r_val;
            end
            default: begin
                w_cmp_x = r_val;
                w_cmp_y = w_best;
            end
        endcase
    end
    assign w_ge = w_cmp_x >= w_cmp_y;

    // memory port control
    always_comb begin
        w_we      = 1'b0;
        w_waddr   = w_pos_m1[ADDR_W-1:0];
        w_wdata   = r_val;
        w_raddr_a = '0;
        w_raddr_b = '0;
        unique case (r_state)
            S_EVAL: begin
                if (w_fit && !w_full) begin
                    if (w_new_pos == FILL_W'(1)) begin
                        w_we    = 1'b1;
                        w_waddr = '0;
                    end else begin
                        w_raddr_a = w_npar_m1[ADDR_W-1:0];
                    end
                end
            end
            S_UP: begin
                // hole moves up: either settle the new value or pull the parent down
                w_we      = 1'b1;
                w_wdata   = w_ge ? r_val : r_rd_a;
                w_raddr_a = w_gpar_m1[ADDR_W-1:0];
            end
            S_UP_FIN: begin
                w_we    = 1'b1;
                w_waddr = '0;
            end
            S_DN_RD: begin
                if (w_dn_leaf) begin
                    w_we = 1'b1;
                end else begin
                    w_raddr_a = w_left_m1[ADDR_W-1:0];
                    w_raddr_b = w_child2[ADDR_W-1:0];
                end
            end
            S_DN_CMP: begin
                w_we    = 1'b1;
                w_wdata = w_ge ? r_val : w_best;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd_a <= r_mem[w_raddr_a];
        r_rd_b <= r_mem[w_raddr_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_val <= s_axis_tdata[DUR_W-1:0];
                        r_dl  <= s_axis_tdata[2*DUR_W-1:DUR_W];
                        if (s_axis_tuser) begin
                            r_fill  <= '0;
                            r_total <= '0;
                        end
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (w_fit) begin
                        if (w_full) begin
                            r_outcome <= OC_OVERFLOW;
                            r_state   <= S_OUT;
                        end else begin
                            r_fill    <= w_new_pos;
                            r_total   <= r_total + r_val;
                            r_pos     <= w_new_pos;
                            r_outcome <= OC_ACCEPT;
                            r_state   <= (w_new_pos == FILL_W'(1)) ? S_OUT : S_UP;
                        end
                    end else if (r_fill != '0 && !w_ge) begin
                        // root is strictly longer: swap it out for this job
                        r_total   <= r_total - r_rd_a + r_val;
                        r_pos     <= FILL_W'(1);
                        r_outcome <= OC_REPLACE;
                        r_state   <= S_DN_RD;
                    end else begin
                        r_outcome <= OC_REJECT;
                        r_state   <= S_OUT;
                    end
                end
                S_UP: begin
                    if (w_ge) begin
                        r_state <= S_OUT;
                    end else begin
                        r_pos   <= w_parent;
                        r_state <= (w_parent == FILL_W'(1)) ? S_UP_FIN : S_UP;
                    end
                end
                S_UP_FIN: begin
                    r_state <= S_OUT;
                end
                S_DN_RD: begin
                    r_state <= w_dn_leaf ? S_OUT : S_DN_CMP;
                end
                S_DN_CMP: begin
                    if (w_ge) begin
                        r_state <= S_OUT;
                    end else begin
                        r_pos   <= w_child[FILL_W-1:0];
                        r_state <= S_DN_RD;
                    end
                end
                S_OUT: begin
                    if (w_out_load) begin
                        r_out_outcome <= r_outcome;
                        r_out_cnt     <= w_cnt_ext[CNT_W-1:0];
                        r_out_total   <= r_total;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // count field is the fill masked to its port width
    assign w_cnt_ext = {{CNT_W{1'b0}}, r_fill};

    assign s_axis_tready = (r_state == S_IDLE) && i_rst_n;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{M_PAD_W{1'b0}}, r_out_total, r_out_cnt, r_out_outcome};

endmodule

`default_nettype wire

// ----- rtl/core/djsel_checker.sv -----
// port-level checks for the deadline job selector, bound to the top level
// depends on djsel_pkg and deadline_job_selector_maxheap_unit
`default_nettype none

module djsel_checker #(
    parameter int HEAP_DEPTH = djsel_pkg::HEAP_DEPTH_DEF
) (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            s_axis_tvalid,
    input wire logic                            s_axis_tready,
    input wire logic                            m_axis_tvalid,
    input wire logic                            m_axis_tready,
    input wire logic [djsel_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    import djsel_pkg::*;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(HEAP_DEPTH);
    localparam bit CNT_FITS = HEAP_DEPTH < (1 << CNT_W);

    logic [OUTCOME_W-1:0] w_oc;
    logic [CNT_W-1:0]     w_cnt;
    logic [DUR_W-1:0]     w_tot;

    assign w_oc  = m_axis_tdata[OUTCOME_W-1:0];
    assign w_cnt = m_axis_tdata[OUTCOME_W+CNT_W-1:OUTCOME_W];
    assign w_tot = m_axis_tdata[OUTCOME_W+CNT_W +: DUR_W];

    // one job at a time: busy right after a transaction
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("selector took a second job while busy");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result changed while stalled");

    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && w_oc == OC_OVERFLOW) |-> (w_cnt == DEPTH_CNT))
        else $error("overflow reported with heap not full");

    a_selected_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CNT_FITS && m_axis_tvalid && (w_oc == OC_ACCEPT || w_oc == OC_REPLACE))
        |-> (w_cnt != '0))
        else $error("job selected but count is zero");

    // an empty selection carries no time
    a_empty_zero_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CNT_FITS && m_axis_tvalid && w_cnt == '0) |-> (w_tot == '0))
        else $error("empty selection with nonzero total");

endmodule

bind deadline_job_selector_maxheap_unit djsel_checker #(
    .HEAP_DEPTH(HEAP_DEPTH)
) u_djsel_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ----- sim/deadline_job_selector_maxheap_unit_test.sv -----
// self-checking testbench for deadline_job_selector_maxheap_unit
// depends on djsel_pkg and the top level; predicts each result with its own max-heap model
`default_nettype none

module deadline_job_selector_maxheap_unit_test;
    import djsel_pkg::*;

    localparam int     DEPTH = HEAP_DEPTH_DEF;
    localparam longint DMAX  = 64'h7FFF_FFFF;

    typedef struct {
        t_outcome           outcome;
        logic [CNT_W-1:0]   count;
        logic [DUR_W-1:0]   total;
    } t_selection_result;

    // tracks the selected job set and queues the result each job should give
    class selection_scoreboard;
        logic [DUR_W-1:0]  sel_heap [1:DEPTH];
        int unsigned       sel_fill;
        logic [DUR_W-1:0]  sel_total;
        t_selection_result due_results [$];
        int unsigned       mismatches;

        function void take_job(logic [DUR_W-1:0] dur, logic [DUR_W-1:0] dl, logic first);
            t_selection_result res;
            logic [DUR_W:0]    need;
            logic [DUR_W-1:0]  tmp;
            int unsigned       pos;
            int unsigned       kid;
            if (first) begin
                sel_fill  = 0;
                sel_total = '0;
            end
            need = {1'b0, sel_total} + {1'b0, dur};
            if (need <= {1'b0, dl}) begin
                if (sel_fill >= DEPTH) begin
                    res.outcome = OC_OVERFLOW;
                end else begin
                    sel_fill++;
                    sel_heap[sel_fill] = dur;
                    pos = sel_fill;
                    while (pos > 1 && sel_heap[pos / 2] < sel_heap[pos]) begin
                        tmp                = sel_heap[pos / 2];
                        sel_heap[pos / 2]  = sel_heap[pos];
                        sel_heap[pos]      = tmp;
                        pos                = pos / 2;
                    end
                    sel_total   = sel_total + dur;
                    res.outcome = OC_ACCEPT;
                end
            end else if (sel_fill > 0 && sel_heap[1] > dur) begin
                // longest selected job swapped out, new root sifts down
                sel_total   = sel_total - sel_heap[1] + dur;
                sel_heap[1] = dur;
                pos = 1;
                while (pos <= sel_fill / 2) begin
                    kid = 2 * pos;
                    if (kid < sel_fill && sel_heap[kid + 1] > sel_heap[kid])
                        kid++;
                    if (sel_heap[pos] >= sel_heap[kid])
                        break;
                    tmp           = sel_heap[pos];
                    sel_heap[pos] = sel_heap[kid];
                    sel_heap[kid] = tmp;
                    pos           = kid;
                end
                res.outcome = OC_REPLACE;
            end else begin
                res.outcome = OC_REJECT;
            end
            res.count = sel_fill[CNT_W-1:0];
            res.total = sel_total;
            due_results.push_back(res);
        endfunction

        function void check_outcome(logic [M_TDATA_W-1:0] word);
            t_selection_result want;
            logic [OUTCOME_W-1:0] got_outcome;
            logic [CNT_W-1:0]     got_count;
            logic [DUR_W-1:0]     got_total;
            got_outcome = word[OUTCOME_W-1:0];
            got_count   = word[OUTCOME_W +: CNT_W];
            got_total   = word[OUTCOME_W + CNT_W +: DUR_W];
            if (due_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, word);
                mismatches++;
                return;
            end
            want = due_results.pop_front();
            if (got_outcome !== want.outcome) begin
                $display("%0t: outcome expected %0d actual %0d", $time, want.outcome,
                         got_outcome);
                mismatches++;
            end
            if (got_count !== want.count) begin
                $display("%0t: accepted_count expected %0d actual %0d", $time, want.count,
                         got_count);
                mismatches++;
            end
            if (got_total !== want.total) begin
                $display("%0t: total_time expected %0d actual %0d", $time, want.total,
                         got_total);
                mismatches++;
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic                 s_axis_tuser  = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;

    selection_scoreboard board = new();
    bit     rst_done  = 1'b0;
    bit     src_idle  = 1'b1;
    bit     sink_idle = 1'b1;
    bit     hold_long = 1'b0;
    longint last_dl   = 0;

    deadline_job_selector_maxheap_unit #(
        .HEAP_DEPTH(DEPTH)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        rst_done = 1'b1;
    end

    initial begin
        #4_000_000;
        $display("deadline_job_selector_maxheap_unit regression: fail");
        $finish;
    end

    function automatic longint clamp_dl(longint v);
        return (v > DMAX) ? DMAX : v;
    endfunction

    // valid stays up across back-to-back jobs; lowered only for a gap
    task automatic offer_job(logic [DUR_W-1:0] dur, logic [DUR_W-1:0] dl, logic first);
        int unsigned gap;
        gap = src_idle ? $urandom_range(0, 9) : 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{S_PAD_W{1'b0}}, dl, dur};
        s_axis_tuser  <= first;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        board.take_job(dur, dl, first);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (board.due_results.size() != 0) @(posedge i_clk);
    endtask

    // mostly in-order deadlines steered to fit, replace or reject; a few noise jobs
    task automatic random_job(logic first, int unsigned fit_pct, bit may_restart);
        longint      dur;
        longint      dl;
        longint      tot;
        longint      top;
        longint      room;
        int unsigned roll;
        bit          noise;
        roll  = $urandom_range(0, 99);
        noise = (roll >= 95);
        if (noise && may_restart && $urandom_range(0, 4) == 0)
            first = 1'b1;
        if (first) begin
            tot     = 0;
            top     = 0;
            last_dl = $urandom_range(0, 1000);
        end else begin
            tot = board.sel_total;
            top = (board.sel_fill != 0) ? board.sel_heap[1] : 0;
        end
        if (noise) begin
            dur = ($urandom_range(0, 1) != 0) ? ($urandom & DMAX) : $urandom_range(0, 3000);
            dl  = $urandom & DMAX;
        end else if (roll < fit_pct) begin
            dur = $urandom_range(0, 3000);
            dl  = clamp_dl(tot + dur + $urandom_range(0, 400));
            if (dl < last_dl)
                dl = last_dl;
            last_dl = dl;
        end else begin
            dl   = clamp_dl(last_dl + $urandom_range(0, 40));
            room = dl - tot + 1;
            if (room < 0)
                room = 0;
            if (top > room && $urandom_range(0, 7) == 0)
                dur = top;
            else if (top > room && $urandom_range(0, 3) != 0)
                dur = room + ($urandom % (top - room));
            else
                dur = clamp_dl(room + $urandom_range(0, 50));
            last_dl = dl;
        end
        offer_job(dur[DUR_W-1:0], dl[DUR_W-1:0], first);
    endtask

    task automatic short_sets(int unsigned quota, int unsigned hold_at);
        int unsigned sent;
        int unsigned len;
        sent = 0;
        while (sent < quota) begin
            len       = $urandom_range(1, 25);
            src_idle  = ($urandom_range(0, 3) != 0);
            sink_idle = ($urandom_range(0, 3) != 0);
            for (int i = 0; i < len; i++) begin
                if (sent == hold_at)
                    hold_long = 1'b1;
                random_job(i == 0, 60, 1'b1);
                sent++;
            end
        end
    endtask

    // result side: random stall per transaction, plus one long hold-off on request
    initial begin : result_sink
        int unsigned stall;
        wait (rst_done);
        forever begin
            if (hold_long) begin
                m_axis_tready <= 1'b0;
                repeat (300) @(posedge i_clk);
                hold_long = 1'b0;
            end
            stall = sink_idle ? $urandom_range(0, 9) : 0;
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
            board.check_outcome(m_axis_tdata);
        end
    end

    initial begin : job_source
        wait (rst_done);

        // zero job on zero deadline, full-scale job, then replace, reject, accept
        offer_job(31'd0, 31'd0, 1'b1);
        offer_job(31'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b1);
        offer_job(31'd1, 31'h7FFF_FFFF, 1'b0);
        offer_job(31'd5, 31'd5, 1'b0);
        offer_job(31'd1, 31'd5, 1'b0);
        // equal to the longest selected job: no swap
        offer_job(31'd1, 31'd2, 1'b0);
        // empty set and a job that misses
        offer_job(31'd10, 31'd3, 1'b1);
        // deadline going backward
        offer_job(31'd3, 31'd100, 1'b0);
        offer_job(31'd2, 31'd1, 1'b0);
        // alternating bit patterns, total reaches all ones
        offer_job(31'h2AAA_AAAA, 31'h5555_5555, 1'b1);
        offer_job(31'h5555_5555, 31'h7FFF_FFFF, 1'b0);
        offer_job(31'h5555_5555, 31'h2AAA_AAAA, 1'b1);
        offer_job(31'h2AAA_AAAA, 31'h2AAA_AAAA, 1'b0);
        // swap at the root with two children below
        offer_job(31'd5, 31'd100, 1'b1);
        offer_job(31'd7, 31'd100, 1'b0);
        offer_job(31'd3, 31'd100, 1'b0);
        offer_job(31'd4, 31'd15, 1'b0);
        offer_job(31'd6, 31'd15, 1'b0);
        offer_job(31'd0, 31'd15, 1'b0);
        offer_job(31'd2, 31'd12, 1'b0);

        short_sets(40, 15);
        drain_results();

        // one set long enough to fill the heap, then overflow, replace and reject on it
        src_idle  = 1'b1;
        sink_idle = 1'b1;
        random_job(1'b1, 90, 1'b0);
        while (board.sel_fill < DEPTH) begin
            if (board.sel_fill == DEPTH / 2)
                src_idle = 1'b0;
            random_job(1'b0, 90, 1'b0);
        end
        src_idle = 1'b1;
        for (int i = 0; i < 30; i++)
            random_job(1'b0, 50, 1'b0);
        drain_results();

        short_sets(20, 10);
        drain_results();
        repeat (60) @(posedge i_clk);
        if (board.mismatches == 0)
            $display("deadline_job_selector_maxheap_unit regression: pass");
        else
            $display("deadline_job_selector_maxheap_unit regression: fail");
        $finish;
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/core/djsel_pkg.sv
rtl/core/deadline_job_selector_maxheap_unit.sv
rtl/core/djsel_checker.sv
sim/deadline_job_selector_maxheap_unit_test.sv
